// ===== sv/itrt_pkg.sv =====
// Shared types and constants for the integer to radix text converter.
package itrt_pkg;

  localparam int unsigned CELL_W = 6;

  localparam logic [CELL_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [CELL_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [CELL_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [CELL_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [CELL_W-1:0] DIGIT_MAX   = 6'd9;
  localparam logic [CELL_W-1:0] LETTER_OFS  = 6'd10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  localparam logic ACT_SIGNED = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] digit_char(input logic [CELL_W-1:0] d);
    logic [7:0] c;
    if (d > DIGIT_MAX) begin
      c = CHAR_A + {2'b00, d - LETTER_OFS};
    end else begin
      c = CHAR_ZERO + {2'b00, d};
    end
    return c;
  endfunction

endpackage

// ===== sv/integer_to_radix_text.sv =====
// Integer to radix text converter: bit-serial base conversion and character emission.
// Conversion shifts the value into the digit cells one bit a cycle; emission then emits a '-' for a
// negative signed decimal value and scans out one cell a cycle while the output is free (leading
// zero cells are dropped without waiting). A new value is accepted only in idle, after the last one.
// Reset: rst (synchronous) returns to idle, drops m_tvalid and sets the radix to 10.
module integer_to_radix_text #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        radix_wr_en,
  input  logic [5:0]  radix_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] char_code
  output logic        m_tlast    // last_char
);

  localparam int unsigned CW    = itrt_pkg::CELL_W;
  localparam int unsigned CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(VALUE_WIDTH - 1);

  itrt_pkg::state_t state, state_next;

  logic [CW-1:0]          radix;
  logic [VALUE_WIDTH-1:0] mag;
  logic [CW-1:0]          cells [VALUE_WIDTH];
  logic [CNT_W-1:0]       cnt;
  logic                   neg_pend;
  logic                   seen;

  logic                   accept;
  logic                   out_free;
  logic                   conv_step;
  logic                   emit_shift;
  logic                   emit_char;
  logic                   emit_minus;
  logic                   load_out;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] gen, prop_or_gen;
  logic [VALUE_WIDTH:0]   carry_sum;
  logic [VALUE_WIDTH-1:0] carry_in;
  logic [CW-1:0]          cell_new [VALUE_WIDTH];
  logic [CW-1:0]          top;
  logic                   top_live;

  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign in_val   = s_tdata[VALUE_WIDTH-1:0];
  assign in_neg   = (s_tuser == itrt_pkg::ACT_SIGNED) && (radix == itrt_pkg::RADIX_DEC)
                    && in_val[VALUE_WIDTH-1];

  // Doubling every digit cell: generate when 2d >= r, propagate when only 2d+1 reaches r.
  // The carries ripple like an adder's, so one wide add resolves them.
  always_comb begin
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      gen[i]         = ({cells[i], 1'b0} >= {1'b0, radix});
      prop_or_gen[i] = ({cells[i], 1'b1} >= {1'b0, radix});
    end
  end

  assign carry_sum = {1'b0, prop_or_gen} + {1'b0, gen} + {{VALUE_WIDTH{1'b0}}, mag[VALUE_WIDTH-1]};
  assign carry_in  = carry_sum[VALUE_WIDTH-1:0] ^ prop_or_gen ^ gen;

  always_comb begin
    logic [CW:0] t;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      t = {cells[i], carry_in[i]};
      if (t >= {1'b0, radix}) begin
        cell_new[i] = CW'(t - {1'b0, radix});
      end else begin
        cell_new[i] = t[CW-1:0];
      end
    end
  end

  assign top      = cells[VALUE_WIDTH-1];
  assign top_live = seen | (top != '0) | (cnt == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itrt_pkg::ST_IDLE: begin
        if (accept) state_next = itrt_pkg::ST_CONV;
      end
      itrt_pkg::ST_CONV: begin
        if (cnt == '0) state_next = itrt_pkg::ST_EMIT;
      end
      itrt_pkg::ST_EMIT: begin
        if (emit_shift && cnt == '0) state_next = itrt_pkg::ST_IDLE;
      end
      default: state_next = itrt_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = 1'b0;
    conv_step  = 1'b0;
    emit_shift = 1'b0;
    emit_char  = 1'b0;
    emit_minus = 1'b0;
    unique case (state)
      itrt_pkg::ST_IDLE: s_tready = 1'b1;
      itrt_pkg::ST_CONV: conv_step = 1'b1;
      itrt_pkg::ST_EMIT: begin
        if (neg_pend) begin
          emit_minus = out_free;
        end else if (!top_live) begin
          emit_shift = 1'b1;
        end else if (out_free) begin
          emit_shift = 1'b1;
          emit_char  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign load_out = emit_char | emit_minus;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= itrt_pkg::ST_IDLE;
      radix    <= itrt_pkg::RADIX_RESET;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      neg_pend <= 1'b0;
      seen     <= 1'b0;
    end else begin
      state <= state_next;
      if (radix_wr_en) begin
        if (radix_wr_data < itrt_pkg::RADIX_MIN) begin
          radix <= itrt_pkg::RADIX_MIN;
        end else if (radix_wr_data > itrt_pkg::RADIX_MAX) begin
          radix <= itrt_pkg::RADIX_MAX;
        end else begin
          radix <= radix_wr_data;
        end
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        cnt      <= CNT_TOP;
        neg_pend <= in_neg;
        seen     <= 1'b0;
      end else if (conv_step) begin
        cnt <= (cnt == '0) ? CNT_TOP : cnt - 1'b1;
      end else if (emit_shift) begin
        cnt <= cnt - 1'b1;
      end
      if (emit_minus) neg_pend <= 1'b0;
      if (emit_char) seen <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mag <= in_neg ? (~in_val + 1'b1) : in_val;
      for (int i = 0; i < VALUE_WIDTH; i++) cells[i] <= '0;
    end else if (conv_step) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      for (int i = 0; i < VALUE_WIDTH; i++) cells[i] <= cell_new[i];
    end else if (emit_shift) begin
      for (int i = VALUE_WIDTH - 1; i > 0; i--) cells[i] <= cells[i-1];
      cells[0] <= '0;
    end
    if (emit_minus) begin
      m_tdata <= itrt_pkg::CHAR_MINUS;
      m_tlast <= 1'b0;
    end else if (emit_char) begin
      m_tdata <= itrt_pkg::digit_char(top);
      m_tlast <= (cnt == '0);
    end
  end

endmodule
